@@ rtl/p2b_pkg.sv @@
// Package for the pixel to BGRA8 converter: source format codes, pipeline
// sizes and the sRGB threshold table built at elaboration.
// No dependencies.
package p2b_pkg;

  // Source format register codes
  typedef enum logic [1:0] {
    FMT_BGRA8 = 2'd0,
    FMT_RGBA8 = 2'd1,
    FMT_FP16  = 2'd2
  } fmt_t;

  localparam int CodeBits   = 8;               // one search step per code bit
  localparam int NumStages  = CodeBits + 1;    // entry stage plus search stages
  localparam int NumCodes   = 255;
  localparam int MagBits    = 15;
  localparam logic [MagBits-1:0] MagOne = 15'h3C00;  // half code of 1.0
  localparam logic [7:0] AlphaOpaque = 8'hFF;

  typedef logic [NumCodes-1:0][MagBits-1:0] thr_tab_t;
  typedef logic [NumStages-1:0] stage_vec_t;

  // True when the exact sRGB code of positive finite half h (below 1.0)
  // is greater than k. Linear segment compares against the rounded scale,
  // power segment uses the exact integer test of the 1/2.4 power curve.
  function automatic logic code_above(input logic [MagBits-1:0] h, input int k);
    logic [4:0]   expo;
    logic [63:0]  v;
    logic [63:0]  lin_lhs;
    logic [63:0]  lin_rhs;
    logic [319:0] lhs;
    logic [319:0] rhs;
    logic [319:0] base;
    expo = h[14:10];
    if (expo == 5'd0) v = {54'd0, h[9:0]};
    else v = ({53'd0, 1'b1, h[9:0]}) << (expo - 5'd1);
    if (v * 64'd10000000 <= (64'd31308 << 24)) begin
      lin_lhs = v * 64'd32946 + (64'd5 << 24);
      lin_rhs = (64'(k) + 64'd1) * (64'd10 << 24);
      return lin_lhs >= lin_rhs;
    end
    lhs = 320'd1;
    for (int i = 0; i < 5; i++) lhs = lhs * {256'd0, v};
    for (int i = 0; i < 12; i++) lhs = lhs * 320'd10761;
    base = 320'(40 * k + 581);
    rhs = 320'd1;
    for (int i = 0; i < 12; i++) rhs = rhs * base;
    rhs = rhs << 120;
    return lhs >= rhs;
  endfunction

  // Smallest half magnitude whose code exceeds k, or 1.0 if none below it
  function automatic logic [MagBits-1:0] thr_find(input int k);
    int lo;
    int hi;
    int mid;
    lo = 1;
    hi = int'(MagOne);
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (code_above(MagBits'(mid), k)) hi = mid;
      else lo = mid + 1;
    end
    return MagBits'(lo);
  endfunction

  function automatic thr_tab_t thr_build();
    thr_tab_t t;
    for (int k = 0; k < NumCodes; k++) t[k] = thr_find(k);
    return t;
  endfunction

  // Ascending thresholds: code = number of entries at or below the magnitude
  localparam thr_tab_t SrgbThr = thr_build();

endpackage

@@ rtl/p2b_if.sv @@
// Stream interfaces of the pixel to BGRA8 converter: input pixel channel
// and output BGRA8 channel, valid/ready handshake. No dependencies.
interface p2b_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] first_channel;
  logic [15:0] second_channel;
  logic [15:0] third_channel;
  logic        frame_end_in;

  modport source (output valid, first_channel, second_channel, third_channel,
                  frame_end_in, input ready);
  modport sink (input valid, first_channel, second_channel, third_channel,
                frame_end_in, output ready);
endinterface

interface p2b_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  logic [7:0] alpha;
  logic       frame_end_out;

  modport source (output valid, blue, green, red, alpha, frame_end_out,
                  input ready);
  modport sink (input valid, blue, green, red, alpha, frame_end_out,
                output ready);
endinterface

@@ rtl/pixel_to_bgra8_converter_top.sv @@
// Top level of the pixel to BGRA8 converter: three channel lanes, the
// valid pipeline, the format register and the merge stage.
// Depends on p2b_pkg, p2b_if, p2b_lane and p2b_merge.

// Converts one pixel per item to opaque BGRA8 at one item per clock unless
// out_px.ready stalls. The cfg_wdata register selects BGRA8 passthrough,
// RGBA8 red/blue swap, or linear FP16 to 8-bit sRGB; write it only while the
// block is empty. Each item passes an entry stage, eight binary search
// stages over a 255-entry threshold table (one code bit per stage, per lane)
// and the output register. The pipeline advances any stage whose successor
// is free, so bubbles close up and the input keeps flowing while a finished
// item waits on out_px.ready, until all stages fill. Alpha is always 255.
module pixel_to_bgra8_converter_top (
  input  logic        clk,
  input  logic        rst_n,
  p2b_in_if.sink      in_px,
  p2b_out_if.source   out_px,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata
);

  localparam int NS = p2b_pkg::NumStages;

  p2b_pkg::fmt_t       fmt_r;
  p2b_pkg::stage_vec_t v_r;
  p2b_pkg::stage_vec_t fe_r;
  p2b_pkg::stage_vec_t free;
  logic                merge_free;
  logic [7:0]          code [0:2];
  logic [7:0]          lo_b [0:2];

  // Format register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= p2b_pkg::FMT_BGRA8;
    end else if (cfg_we) begin
      fmt_r <= p2b_pkg::fmt_t'(cfg_wdata);
    end
  end

  // A stage can load when empty or when its item moves on
  assign free[NS-1] = !v_r[NS-1] || merge_free;
  for (genvar s = 0; s < NS - 1; s++) begin : g_free
    assign free[s] = !v_r[s] || free[s+1];
  end

  assign in_px.ready = free[0];

  // Valid and frame-end pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (free[0]) begin
      v_r[0] <= in_px.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free[0]) begin
      fe_r[0] <= in_px.frame_end_in;
    end
  end

  for (genvar s = 1; s < NS; s++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (free[s]) begin
        v_r[s] <= v_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (free[s]) begin
        fe_r[s] <= fe_r[s-1];
      end
    end
  end

  // Channel lanes
  p2b_lane u_lane0 (
    .clk     (clk),
    .h       (in_px.first_channel),
    .ld      (free),
    .code    (code[0]),
    .lo_byte (lo_b[0])
  );

  p2b_lane u_lane1 (
    .clk     (clk),
    .h       (in_px.second_channel),
    .ld      (free),
    .code    (code[1]),
    .lo_byte (lo_b[1])
  );

  p2b_lane u_lane2 (
    .clk     (clk),
    .h       (in_px.third_channel),
    .ld      (free),
    .code    (code[2]),
    .lo_byte (lo_b[2])
  );

  // Merge and output register
  p2b_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .stg_valid     (v_r[NS-1]),
    .stg_frame_end (fe_r[NS-1]),
    .fmt           (fmt_r),
    .code0         (code[0]),
    .code1         (code[1]),
    .code2         (code[2]),
    .byte0         (lo_b[0]),
    .byte1         (lo_b[1]),
    .byte2         (lo_b[2]),
    .free          (merge_free),
    .out_px        (out_px)
  );

endmodule

@@ rtl/p2b_lane.sv @@
// One channel lane: FP16 to sRGB8 code by a pipelined binary search over
// the threshold table, plus the raw low byte for the 8-bit formats.
// Depends on p2b_pkg.
module p2b_lane (
  input  logic                    clk,
  input  logic [15:0]             h,
  input  p2b_pkg::stage_vec_t     ld,
  output logic [7:0]              code,
  output logic [7:0]              lo_byte
);

  logic [p2b_pkg::MagBits-1:0] mag_r  [0:p2b_pkg::NumStages-1];
  logic [7:0]                  byte_r [0:p2b_pkg::NumStages-1];
  logic [7:0]                  code_r [0:p2b_pkg::NumStages-1];
  logic                        nan;
  logic [p2b_pkg::MagBits-1:0] mag_in;

  // Negative values and NaN search as zero and land on code 0
  assign nan    = (&h[14:10]) && (|h[9:0]);
  assign mag_in = (h[15] || nan) ? '0 : h[14:0];

  // Entry stage
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      mag_r[0]  <= mag_in;
      byte_r[0] <= h[7:0];
      code_r[0] <= '0;
    end
  end

  // Search stages, most significant code bit first
  for (genvar s = 1; s < p2b_pkg::NumStages; s++) begin : g_step
    logic [7:0] cand;
    logic       take;
    assign cand = code_r[s-1] | (8'd1 << (p2b_pkg::CodeBits - s));
    assign take = p2b_pkg::SrgbThr[cand - 8'd1] <= mag_r[s-1];

    always_ff @(posedge clk) begin
      if (ld[s]) begin
        mag_r[s]  <= mag_r[s-1];
        byte_r[s] <= byte_r[s-1];
        code_r[s] <= take ? cand : code_r[s-1];
      end
    end
  end

  assign code    = code_r[p2b_pkg::NumStages-1];
  assign lo_byte = byte_r[p2b_pkg::NumStages-1];

endmodule

@@ rtl/p2b_merge.sv @@
// Merge stage: picks lane codes or raw bytes by source format into the
// BGRA8 output register. Depends on p2b_pkg and p2b_if.
module p2b_merge (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              stg_valid,
  input  logic              stg_frame_end,
  input  p2b_pkg::fmt_t     fmt,
  input  logic [7:0]        code0,
  input  logic [7:0]        code1,
  input  logic [7:0]        code2,
  input  logic [7:0]        byte0,
  input  logic [7:0]        byte1,
  input  logic [7:0]        byte2,
  output logic              free,
  p2b_out_if.source         out_px
);

  logic       valid_r;
  logic [7:0] blue_r, green_r, red_r;
  logic [7:0] blue_nxt, green_nxt, red_nxt;
  logic       fe_r;

  assign free = !valid_r || out_px.ready;

  // Channel selection
  always_comb begin
    unique case (fmt)
      p2b_pkg::FMT_RGBA8: begin
        blue_nxt  = byte2;
        green_nxt = byte1;
        red_nxt   = byte0;
      end
      p2b_pkg::FMT_FP16: begin
        blue_nxt  = code2;
        green_nxt = code1;
        red_nxt   = code0;
      end
      default: begin
        blue_nxt  = byte0;
        green_nxt = byte1;
        red_nxt   = byte2;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= stg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free) begin
      blue_r  <= blue_nxt;
      green_r <= green_nxt;
      red_r   <= red_nxt;
      fe_r    <= stg_frame_end;
    end
  end

  assign out_px.valid         = valid_r;
  assign out_px.blue          = blue_r;
  assign out_px.green         = green_r;
  assign out_px.red           = red_r;
  assign out_px.alpha         = p2b_pkg::AlphaOpaque;
  assign out_px.frame_end_out = fe_r;

endmodule
